[rtl/kmq_pkg.sv]
package kmq_pkg;

    localparam logic [2:0] ACT_REGISTER   = 3'd0;
    localparam logic [2:0] ACT_UNREGISTER = 3'd1;
    localparam logic [2:0] ACT_SEND       = 3'd2;
    localparam logic [2:0] ACT_RECEIVE    = 3'd3;
    localparam logic [2:0] ACT_CLEAR_ALL  = 3'd4;

    localparam logic [2:0] STAT_OK          = 3'd0;
    localparam logic [2:0] STAT_DUPLICATE   = 3'd1;
    localparam logic [2:0] STAT_TABLE_FULL  = 3'd2;
    localparam logic [2:0] STAT_NOT_FOUND   = 3'd3;
    localparam logic [2:0] STAT_QUEUE_FULL  = 3'd4;
    localparam logic [2:0] STAT_EMPTY       = 3'd5;
    localparam logic [2:0] STAT_BAD_LENGTH  = 3'd6;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] mailbox_key;
        logic [31:0] msg_type;
        logic [3:0]  msg_len;
        logic [63:0] msg_payload;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] out_type;
        logic [3:0]  out_len;
        logic [63:0] out_payload;
    } out_item_t;

    typedef enum logic [1:0] {
        KT_NONE,
        KT_CLAIM,
        KT_FREE,
        KT_FREE_ALL
    } kt_op_t;

    typedef struct packed {
        logic hit;
        logic vacant;
    } kt_res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PTR,
        ST_MSG
    } state_t;

    function automatic logic [63:0] byte_mask(input logic [3:0] len);
        logic [63:0] mask;
        mask = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < len) begin
                mask[8*i +: 8] = 8'hff;
            end
        end
        return mask;
    endfunction

endpackage

[rtl/kmq_ram.sv]
module kmq_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/kmq_key_table.sv]
module kmq_key_table #(
    parameter int MAILBOXES = 8,
    parameter int IDX_W     = 3
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [31:0]         lookup_key,
    output kmq_pkg::kt_res_t    res,
    output logic [IDX_W-1:0]    hit_idx,
    output logic [IDX_W-1:0]    vacant_idx,
    input  kmq_pkg::kt_op_t     op,
    input  logic [IDX_W-1:0]    op_idx,
    input  logic [31:0]         op_key
);

    logic [MAILBOXES-1:0] in_use_reg;
    logic [MAILBOXES-1:0] in_use_next;
    logic [31:0]          key_reg [MAILBOXES];

    always_comb begin
        res        = '0;
        hit_idx    = '0;
        vacant_idx = '0;
        for (int i = 0; i < MAILBOXES; i++) begin
            if (!res.hit && in_use_reg[i] && key_reg[i] == lookup_key) begin
                res.hit = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (!res.vacant && !in_use_reg[i]) begin
                res.vacant = 1'b1;
                vacant_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        in_use_next = in_use_reg;
        unique case (op)
            kmq_pkg::KT_NONE: begin
            end
            kmq_pkg::KT_CLAIM: begin
                in_use_next[op_idx] = 1'b1;
            end
            kmq_pkg::KT_FREE: begin
                in_use_next[op_idx] = 1'b0;
            end
            kmq_pkg::KT_FREE_ALL: begin
                in_use_next = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_use_reg <= '0;
        end else begin
            in_use_reg <= in_use_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (op == kmq_pkg::KT_CLAIM) begin
            key_reg[op_idx] <= op_key;
        end
    end

endmodule

[rtl/keyed_multi_queue_mailbox.sv]
// Keyed mailbox table: each of MAILBOXES entries is named by a 32-bit key and owns a ring
// queue of QUEUE_DEPTH messages held in one synchronous message memory, while the queue
// pointers live in a second small memory. Each transaction produces exactly one result.
// A transaction does key match and pointer memory read, then pointer update as the action
// needs, with at most one message memory read or write, then the result register; a new
// transaction is accepted once the previous result has been loaded, so transactions do
// not overlap and a stalled result channel holds the next one back. The key and message
// stores need no clearing pass after reset, and the block is ready as soon as reset ends.
module keyed_multi_queue_mailbox #(
    parameter int MAILBOXES     = 8,
    parameter int QUEUE_DEPTH   = 16,
    parameter int PAYLOAD_BYTES = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  kmq_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output kmq_pkg::out_item_t m_data
);

    localparam int IDX_W  = (MAILBOXES > 1) ? $clog2(MAILBOXES) : 1;
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int PAY_W  = 8 * PAYLOAD_BYTES;
    localparam int PQ_W   = 2 * PTR_W + CNT_W;
    localparam int MSG_W  = 36 + PAY_W;
    localparam logic [3:0]       LEN_MAX   = 4'(PAYLOAD_BYTES);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(QUEUE_DEPTH);

    kmq_pkg::state_t    state_reg, state_next;
    kmq_pkg::in_item_t  req_reg;
    kmq_pkg::kt_res_t   kt_res, kt_res_reg;
    logic [IDX_W-1:0]   hit_idx, vacant_idx, hit_idx_reg, vacant_idx_reg;
    logic [2:0]         status_reg, status_next;
    logic               rx_reg, rx_next;
    logic               m_valid_reg;
    kmq_pkg::out_item_t m_data_reg, result;

    kmq_pkg::kt_op_t    kt_op;
    logic [IDX_W-1:0]   kt_idx;

    logic               ptr_rd_en, ptr_we;
    logic [IDX_W-1:0]   ptr_wr_addr;
    logic [PQ_W-1:0]    ptr_wr_data, ptr_rd_data;
    logic [PTR_W-1:0]   cur_head, cur_tail;
    logic [CNT_W-1:0]   cur_cnt;

    logic               msg_rd_en, msg_we;
    logic [IDX_W+PTR_W-1:0] msg_addr;
    logic [MSG_W-1:0]   msg_wr_data, msg_rd_data;
    logic [63:0]        masked_payload;

    logic               accept, load_out;

    assign accept   = s_valid && s_ready;
    assign load_out = (state_reg == kmq_pkg::ST_MSG) && (!m_valid_reg || m_ready);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign cur_head = ptr_rd_data[PQ_W-1 -: PTR_W];
    assign cur_tail = ptr_rd_data[CNT_W +: PTR_W];
    assign cur_cnt  = ptr_rd_data[CNT_W-1:0];

    assign masked_payload = req_reg.msg_payload & kmq_pkg::byte_mask(req_reg.msg_len);
    assign msg_wr_data    = {req_reg.msg_type, req_reg.msg_len, masked_payload[PAY_W-1:0]};

    kmq_key_table #(
        .MAILBOXES (MAILBOXES),
        .IDX_W     (IDX_W)
    ) u_key_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .lookup_key (s_data.mailbox_key),
        .res        (kt_res),
        .hit_idx    (hit_idx),
        .vacant_idx (vacant_idx),
        .op         (kt_op),
        .op_idx     (kt_idx),
        .op_key     (req_reg.mailbox_key)
    );

    kmq_ram #(
        .DATA_W (PQ_W),
        .ADDR_W (IDX_W)
    ) u_ptr_ram (
        .aclk    (aclk),
        .we      (ptr_we),
        .wr_addr (ptr_wr_addr),
        .wr_data (ptr_wr_data),
        .rd_en   (ptr_rd_en),
        .rd_addr (hit_idx),
        .rd_data (ptr_rd_data)
    );

    kmq_ram #(
        .DATA_W (MSG_W),
        .ADDR_W (IDX_W + PTR_W)
    ) u_msg_ram (
        .aclk    (aclk),
        .we      (msg_we),
        .wr_addr (msg_addr),
        .wr_data (msg_wr_data),
        .rd_en   (msg_rd_en),
        .rd_addr (msg_addr),
        .rd_data (msg_rd_data)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            kmq_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = kmq_pkg::ST_PTR;
                end
            end
            kmq_pkg::ST_PTR: begin
                state_next = kmq_pkg::ST_MSG;
            end
            kmq_pkg::ST_MSG: begin
                if (load_out) begin
                    state_next = kmq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = kmq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        ptr_rd_en   = 1'b0;
        ptr_we      = 1'b0;
        ptr_wr_addr = hit_idx_reg;
        ptr_wr_data = ptr_rd_data;
        msg_rd_en   = 1'b0;
        msg_we      = 1'b0;
        msg_addr    = {hit_idx_reg, cur_tail};
        kt_op       = kmq_pkg::KT_NONE;
        kt_idx      = hit_idx_reg;
        status_next = status_reg;
        rx_next     = rx_reg;
        unique case (state_reg)
            kmq_pkg::ST_IDLE: begin
                s_ready   = 1'b1;
                ptr_rd_en = s_valid;
            end
            kmq_pkg::ST_PTR: begin
                status_next = kmq_pkg::STAT_OK;
                rx_next     = 1'b0;
                unique case (req_reg.action)
                    kmq_pkg::ACT_REGISTER: begin
                        if (kt_res_reg.hit) begin
                            status_next = kmq_pkg::STAT_DUPLICATE;
                        end else if (!kt_res_reg.vacant) begin
                            status_next = kmq_pkg::STAT_TABLE_FULL;
                        end else begin
                            kt_op       = kmq_pkg::KT_CLAIM;
                            kt_idx      = vacant_idx_reg;
                            ptr_we      = 1'b1;
                            ptr_wr_addr = vacant_idx_reg;
                            ptr_wr_data = '0;
                        end
                    end
                    kmq_pkg::ACT_UNREGISTER: begin
                        if (!kt_res_reg.hit) begin
                            status_next = kmq_pkg::STAT_NOT_FOUND;
                        end else begin
                            kt_op = kmq_pkg::KT_FREE;
                        end
                    end
                    kmq_pkg::ACT_SEND: begin
                        if (req_reg.msg_len > LEN_MAX) begin
                            status_next = kmq_pkg::STAT_BAD_LENGTH;
                        end else if (!kt_res_reg.hit) begin
                            status_next = kmq_pkg::STAT_NOT_FOUND;
                        end else if (cur_cnt == CNT_FULL) begin
                            status_next = kmq_pkg::STAT_QUEUE_FULL;
                        end else begin
                            msg_we      = 1'b1;
                            msg_addr    = {hit_idx_reg, cur_tail};
                            ptr_we      = 1'b1;
                            ptr_wr_data = {cur_head,
                                           (cur_tail == PTR_LAST) ? {PTR_W{1'b0}}
                                                                  : cur_tail + 1'b1,
                                           cur_cnt + 1'b1};
                        end
                    end
                    kmq_pkg::ACT_RECEIVE: begin
                        if (!kt_res_reg.hit) begin
                            status_next = kmq_pkg::STAT_NOT_FOUND;
                        end else if (cur_cnt == '0) begin
                            status_next = kmq_pkg::STAT_EMPTY;
                        end else begin
                            rx_next     = 1'b1;
                            msg_rd_en   = 1'b1;
                            msg_addr    = {hit_idx_reg, cur_head};
                            ptr_we      = 1'b1;
                            ptr_wr_data = {(cur_head == PTR_LAST) ? {PTR_W{1'b0}}
                                                                  : cur_head + 1'b1,
                                           cur_tail,
                                           cur_cnt - 1'b1};
                        end
                    end
                    kmq_pkg::ACT_CLEAR_ALL: begin
                        kt_op = kmq_pkg::KT_FREE_ALL;
                    end
                    default: begin
                    end
                endcase
            end
            kmq_pkg::ST_MSG: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        result = '0;
        if (rx_reg) begin
            result.status      = kmq_pkg::STAT_OK;
            result.out_type    = msg_rd_data[MSG_W-1 -: 32];
            result.out_len     = msg_rd_data[PAY_W +: 4];
            result.out_payload = 64'(msg_rd_data[PAY_W-1:0]);
        end else begin
            result.status = status_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= kmq_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg        <= s_data;
            kt_res_reg     <= kt_res;
            hit_idx_reg    <= hit_idx;
            vacant_idx_reg <= vacant_idx;
        end
        status_reg <= status_next;
        rx_reg     <= rx_next;
        if (load_out) begin
            m_data_reg <= result;
        end
    end

endmodule

[bench/keyed_multi_queue_mailbox_tb.sv]
`timescale 1ns / 100ps

module keyed_multi_queue_mailbox_tb;

    localparam int MAILBOXES     = 8;
    localparam int QUEUE_DEPTH   = 16;
    localparam int PAYLOAD_BYTES = 8;
    localparam int SLOTS         = MAILBOXES * QUEUE_DEPTH;
    localparam int PTR_W         = $clog2(QUEUE_DEPTH);

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    kmq_pkg::in_item_t   s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    kmq_pkg::out_item_t  m_data;

    logic              box_used [MAILBOXES];
    logic [31:0]       box_key  [MAILBOXES];
    logic [PTR_W-1:0]  q_head   [MAILBOXES];
    logic [PTR_W-1:0]  q_tail   [MAILBOXES];
    logic [PTR_W:0]    q_count  [MAILBOXES];
    logic [31:0]       msg_type_store [SLOTS];
    logic [3:0]        msg_len_store  [SLOTS];
    logic [63:0]       msg_data_store [SLOTS];

    kmq_pkg::out_item_t replies_due[$];
    kmq_pkg::out_item_t want;
    int        mismatch_count = 0;
    int        ready_hold = 0;
    bit        idling_on = 1'b1;

    keyed_multi_queue_mailbox #(
        .MAILBOXES     (MAILBOXES),
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [63:0] len_mask(input logic [3:0] len);
        if (len >= 8) begin
            return '1;
        end
        return (64'd1 << (8 * len)) - 64'd1;
    endfunction

    function automatic kmq_pkg::in_item_t make_item(input logic [2:0] action,
                                                    input logic [31:0] key,
                                                    input logic [31:0] mtype,
                                                    input logic [3:0] len,
                                                    input logic [63:0] payload);
        kmq_pkg::in_item_t item;
        item.action      = action;
        item.mailbox_key = key;
        item.msg_type    = mtype;
        item.msg_len     = len;
        item.msg_payload = payload;
        return item;
    endfunction

    function automatic kmq_pkg::out_item_t reply_for(input kmq_pkg::in_item_t req);
        kmq_pkg::out_item_t rep;
        int        hit;
        int        vacant;
        int        slot;
        rep = '0;
        rep.status = kmq_pkg::STAT_OK;
        hit = -1;
        vacant = -1;
        for (int i = 0; i < MAILBOXES; i++) begin
            if (hit < 0 && box_used[i] && box_key[i] == req.mailbox_key) begin
                hit = i;
            end
            if (vacant < 0 && !box_used[i]) begin
                vacant = i;
            end
        end
        case (req.action)
            kmq_pkg::ACT_REGISTER: begin
                if (hit >= 0) begin
                    rep.status = kmq_pkg::STAT_DUPLICATE;
                end else if (vacant < 0) begin
                    rep.status = kmq_pkg::STAT_TABLE_FULL;
                end else begin
                    box_used[vacant] = 1'b1;
                    box_key[vacant]  = req.mailbox_key;
                    q_head[vacant]   = '0;
                    q_tail[vacant]   = '0;
                    q_count[vacant]  = '0;
                end
            end
            kmq_pkg::ACT_UNREGISTER: begin
                if (hit < 0) begin
                    rep.status = kmq_pkg::STAT_NOT_FOUND;
                end else begin
                    box_used[hit] = 1'b0;
                end
            end
            kmq_pkg::ACT_SEND: begin
                if (req.msg_len > PAYLOAD_BYTES) begin
                    rep.status = kmq_pkg::STAT_BAD_LENGTH;
                end else if (hit < 0) begin
                    rep.status = kmq_pkg::STAT_NOT_FOUND;
                end else if (q_count[hit] >= QUEUE_DEPTH) begin
                    rep.status = kmq_pkg::STAT_QUEUE_FULL;
                end else begin
                    slot = hit * QUEUE_DEPTH + q_tail[hit];
                    msg_type_store[slot] = req.msg_type;
                    msg_len_store[slot]  = req.msg_len;
                    msg_data_store[slot] = req.msg_payload & len_mask(req.msg_len);
                    q_tail[hit]  = PTR_W'((q_tail[hit] + 1) % QUEUE_DEPTH);
                    q_count[hit] = q_count[hit] + 1'b1;
                end
            end
            kmq_pkg::ACT_RECEIVE: begin
                if (hit < 0) begin
                    rep.status = kmq_pkg::STAT_NOT_FOUND;
                end else if (q_count[hit] == 0) begin
                    rep.status = kmq_pkg::STAT_EMPTY;
                end else begin
                    slot = hit * QUEUE_DEPTH + q_head[hit];
                    rep.out_type    = msg_type_store[slot];
                    rep.out_len     = msg_len_store[slot];
                    rep.out_payload = msg_data_store[slot] & len_mask(msg_len_store[slot]);
                    q_head[hit]  = PTR_W'((q_head[hit] + 1) % QUEUE_DEPTH);
                    q_count[hit] = q_count[hit] - 1'b1;
                end
            end
            kmq_pkg::ACT_CLEAR_ALL: begin
                for (int i = 0; i < MAILBOXES; i++) begin
                    box_used[i] = 1'b0;
                end
            end
            default: begin
            end
        endcase
        return rep;
    endfunction

    task automatic send_item(input kmq_pkg::in_item_t item);
        int gap;
        gap = 0;
        if (idling_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 15);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        replies_due.push_back(reply_for(item));
    endtask

    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_ready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 9) == 0) begin
            ready_hold <= $urandom_range(0, 14);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (replies_due.size() == 0) begin
                $error("unexpected result transaction: status %0d", m_data.status);
                mismatch_count++;
            end else begin
                want = replies_due.pop_front();
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_data.status);
                    mismatch_count++;
                end
                if (m_data.out_type !== want.out_type) begin
                    $error("out_type: expected %h, got %h", want.out_type, m_data.out_type);
                    mismatch_count++;
                end
                if (m_data.out_len !== want.out_len) begin
                    $error("out_len: expected %0d, got %0d", want.out_len, m_data.out_len);
                    mismatch_count++;
                end
                if (m_data.out_payload !== want.out_payload) begin
                    $error("out_payload: expected %h, got %h", want.out_payload,
                           m_data.out_payload);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic test_table_rules();
        logic [31:0] extra_key;
        idling_on = 1'b1;
        send_item(make_item(kmq_pkg::ACT_CLEAR_ALL, '0, '0, '0, '0));
        send_item(make_item(kmq_pkg::ACT_RECEIVE, 32'h1234_5678, '0, '0, '0));
        send_item(make_item(kmq_pkg::ACT_UNREGISTER, 32'h1234_5678, '0, '0, '0));
        send_item(make_item(kmq_pkg::ACT_SEND, 32'h1234_5678, 32'h5, 4'd2, 64'h1234));
        send_item(make_item(kmq_pkg::ACT_SEND, 32'h1234_5678, '1, 4'd15, '1));
        send_item(make_item(kmq_pkg::ACT_REGISTER, 32'h0, '0, '0, '0));
        send_item(make_item(kmq_pkg::ACT_REGISTER, 32'hFFFF_FFFF, '0, '0, '0));
        send_item(make_item(kmq_pkg::ACT_REGISTER, 32'h0, '0, '0, '0));
        send_item(make_item(kmq_pkg::ACT_SEND, 32'h0, '1, 4'd0, '1));
        send_item(make_item(kmq_pkg::ACT_SEND, 32'h0, '0, 4'd8, '1));
        send_item(make_item(kmq_pkg::ACT_SEND, 32'h0, '1, 4'd9, '1));
        send_item(make_item(kmq_pkg::ACT_RECEIVE, 32'h0, '1, '1, '1));
        send_item(make_item(kmq_pkg::ACT_RECEIVE, 32'h0, '0, '0, '0));
        send_item(make_item(kmq_pkg::ACT_RECEIVE, 32'h0, '0, '0, '0));
        for (int a = kmq_pkg::ACT_CLEAR_ALL + 1; a < 8; a++) begin
            send_item(make_item(3'(a), 32'h0, '1, '1, '1));
        end
        repeat (MAILBOXES - 2) begin
            send_item(make_item(kmq_pkg::ACT_REGISTER, $urandom, '0, '0, '0));
        end
        extra_key = $urandom;
        send_item(make_item(kmq_pkg::ACT_REGISTER, extra_key, '0, '0, '0));
        send_item(make_item(kmq_pkg::ACT_REGISTER, 32'hFFFF_FFFF, '0, '0, '0));
        send_item(make_item(kmq_pkg::ACT_UNREGISTER, 32'hFFFF_FFFF, '0, '0, '0));
        send_item(make_item(kmq_pkg::ACT_REGISTER, extra_key, '0, '0, '0));
        send_item(make_item(kmq_pkg::ACT_CLEAR_ALL, '0, '0, '0, '0));
        send_item(make_item(kmq_pkg::ACT_RECEIVE, extra_key, '0, '0, '0));
        send_item(make_item(kmq_pkg::ACT_REGISTER, 32'h0, '0, '0, '0));
        send_item(make_item(kmq_pkg::ACT_RECEIVE, 32'h0, '0, '0, '0));
    endtask

    task automatic test_queue_wrap();
        logic [31:0] key;
        key = $urandom;
        send_item(make_item(kmq_pkg::ACT_REGISTER, key, '0, '0, '0));
        repeat (QUEUE_DEPTH + 1) begin
            send_item(make_item(kmq_pkg::ACT_SEND, key, $urandom,
                                4'($urandom_range(0, PAYLOAD_BYTES)), {$urandom, $urandom}));
        end
        repeat (5) begin
            send_item(make_item(kmq_pkg::ACT_RECEIVE, key, '0, '0, '0));
        end
        repeat (5) begin
            send_item(make_item(kmq_pkg::ACT_SEND, key, $urandom,
                                4'($urandom_range(0, PAYLOAD_BYTES)), {$urandom, $urandom}));
        end
        repeat (QUEUE_DEPTH + 1) begin
            send_item(make_item(kmq_pkg::ACT_RECEIVE, key, '0, '0, '0));
        end
        send_item(make_item(kmq_pkg::ACT_UNREGISTER, key, '0, '0, '0));
    endtask

    task automatic test_random_traffic();
        logic [31:0] key_pool [10];
        logic [31:0] key;
        logic [2:0]  action;
        logic [3:0]  len;
        int          pick;
        int          span;
        int          send_weight;
        int          receive_weight;
        foreach (key_pool[k]) begin
            key_pool[k] = $urandom;
        end
        span = 10;
        send_weight = 36;
        receive_weight = 36;
        for (int n = 0; n < 600; n++) begin
            idling_on = (n < 450) && ((n / 75) % 3 != 2);
            if (n % 50 == 0) begin
                span = $urandom_range(1, 10);
                case ($urandom_range(0, 2))
                    0: begin
                        send_weight = 15;
                        receive_weight = 57;
                    end
                    1: begin
                        send_weight = 36;
                        receive_weight = 36;
                    end
                    default: begin
                        send_weight = 57;
                        receive_weight = 15;
                    end
                endcase
            end
            key = ($urandom_range(0, 15) == 0) ? $urandom : key_pool[$urandom_range(0, span - 1)];
            len = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(PAYLOAD_BYTES + 1, 15))
                                               : 4'($urandom_range(0, PAYLOAD_BYTES));
            pick = $urandom_range(0, 99);
            if (pick < 14) begin
                action = kmq_pkg::ACT_REGISTER;
            end else if (pick < 22) begin
                action = kmq_pkg::ACT_UNREGISTER;
            end else if (pick < 22 + send_weight) begin
                action = kmq_pkg::ACT_SEND;
            end else if (pick < 22 + send_weight + receive_weight) begin
                action = kmq_pkg::ACT_RECEIVE;
            end else if (pick < 96) begin
                action = kmq_pkg::ACT_CLEAR_ALL;
            end else begin
                action = 3'($urandom_range(kmq_pkg::ACT_CLEAR_ALL + 1, 7));
            end
            send_item(make_item(action, key, $urandom, len, {$urandom, $urandom}));
        end
    endtask

    initial begin
        foreach (box_used[i]) begin
            box_used[i] = 1'b0;
            box_key[i]  = '0;
            q_head[i]   = '0;
            q_tail[i]   = '0;
            q_count[i]  = '0;
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_table_rules();
        test_queue_wrap();
        test_random_traffic();
        s_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
